// ----- design/wl1nn_pkg.sv -----
package wl1nn_pkg;

  localparam int MAX_POINTS  = 256;
  localparam int MAX_DIMS    = 8;
  localparam int COORD_BITS  = 16;
  localparam int WEIGHT_BITS = 16;

  localparam int SLOT_W     = 8;
  localparam int DSLOT_W    = 3;
  localparam int CFG_DATA_W = 9;
  localparam int CFG_IDX_W  = 1;
  localparam int DIM_CW     = 4;
  localparam int IDX_OUT_W  = 8;
  localparam int DIST_W     = 40;

  localparam int PT_AW  = $clog2(MAX_POINTS);
  localparam int PT_CW  = $clog2(MAX_POINTS + 1);
  localparam int DIM_AW = $clog2(MAX_DIMS);
  localparam int ABS_W  = COORD_BITS;
  localparam int PROD_W = ABS_W + WEIGHT_BITS;
  localparam int GRP_W  = PROD_W + 1;
  localparam int NGRP   = (MAX_DIMS + 1) / 2;
  localparam int SUM_W  = PROD_W + DIM_AW;

  localparam int FQ_DEPTH = 4;
  localparam int FQ_AW    = $clog2(FQ_DEPTH);
  localparam int FQ_CW    = $clog2(FQ_DEPTH + 1);

  localparam logic [WEIGHT_BITS-1:0] WEIGHT_ONE = WEIGHT_BITS'(4096);

  localparam logic [CFG_IDX_W-1:0] CFG_POINTS_IN_USE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIMS_IN_USE   = 1'b1;

  typedef enum logic [1:0] {
    REQ_POINT  = 2'd0,
    REQ_QUERY  = 2'd1,
    REQ_WEIGHT = 2'd2
  } req_t;

  typedef enum logic {
    ST_IDLE,
    ST_SEARCH
  } state_t;

  typedef struct packed {
    req_t                          op;
    logic                          last;
    logic                          slot_ok;
    logic [SLOT_W-1:0]             point_slot;
    logic [DSLOT_W-1:0]            dim_slot;
    logic signed [COORD_BITS-1:0]  coord;
  } cmd_t;

endpackage

// ----- design/wl1nn_front.sv -----
module wl1nn_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [1:0]                           in_req_type,
  input  logic [wl1nn_pkg::SLOT_W-1:0]         in_point_slot,
  input  logic [wl1nn_pkg::DSLOT_W-1:0]        in_dim_slot,
  input  logic signed [wl1nn_pkg::COORD_BITS-1:0] in_coord_value,
  input  logic                                 in_query_last,
  output logic                                 cmd_valid,
  input  logic                                 cmd_ready,
  output wl1nn_pkg::cmd_t                      cmd
);

  wl1nn_pkg::cmd_t fifo_mem [wl1nn_pkg::FQ_DEPTH];
  logic [wl1nn_pkg::FQ_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [wl1nn_pkg::FQ_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [wl1nn_pkg::FQ_CW-1:0] cnt_r, cnt_nxt;

  wl1nn_pkg::cmd_t new_cmd;
  logic            keep;
  logic            push;
  logic            pop;
  logic            dim_ok;
  logic            pt_ok;

  assign dim_ok = {1'b0, in_dim_slot} < (wl1nn_pkg::DSLOT_W + 1)'(wl1nn_pkg::MAX_DIMS);
  assign pt_ok  = {1'b0, in_point_slot} < (wl1nn_pkg::SLOT_W + 1)'(wl1nn_pkg::MAX_POINTS);

  // Classify the item; the unused request code is accepted and dropped here.
  always_comb begin
    keep               = 1'b1;
    new_cmd.op         = wl1nn_pkg::REQ_POINT;
    new_cmd.last       = 1'b0;
    new_cmd.slot_ok    = dim_ok;
    new_cmd.point_slot = in_point_slot;
    new_cmd.dim_slot   = in_dim_slot;
    new_cmd.coord      = in_coord_value;
    case (in_req_type)
      wl1nn_pkg::REQ_POINT: begin
        new_cmd.op      = wl1nn_pkg::REQ_POINT;
        new_cmd.slot_ok = dim_ok && pt_ok;
      end
      wl1nn_pkg::REQ_QUERY: begin
        new_cmd.op   = wl1nn_pkg::REQ_QUERY;
        new_cmd.last = in_query_last;
      end
      wl1nn_pkg::REQ_WEIGHT: begin
        new_cmd.op = wl1nn_pkg::REQ_WEIGHT;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_ready  = cnt_r != wl1nn_pkg::FQ_CW'(wl1nn_pkg::FQ_DEPTH);
  assign push      = in_valid && in_ready && keep;
  assign cmd_valid = cnt_r != '0;
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = fifo_mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr_r] <= new_cmd;
    end
  end

  a_push_fills : assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("queue count did not follow a push");

  a_depth : assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= wl1nn_pkg::FQ_CW'(wl1nn_pkg::FQ_DEPTH))
    else $error("queue count beyond depth");

endmodule

// ----- design/wl1nn_back.sv -----
module wl1nn_back (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cmd_valid,
  output logic                                   cmd_ready,
  input  wl1nn_pkg::cmd_t                        cmd,
  input  logic                                   cfg_we,
  input  logic [wl1nn_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [wl1nn_pkg::CFG_DATA_W-1:0]       cfg_data,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [wl1nn_pkg::IDX_OUT_W-1:0]        out_nearest_index,
  output logic [wl1nn_pkg::DIST_W-1:0]           out_nearest_distance,
  output logic                                   out_found
);

  localparam int MD = wl1nn_pkg::MAX_DIMS;

  wl1nn_pkg::state_t state_r, state_nxt;

  logic [wl1nn_pkg::CFG_DATA_W-1:0]   points_in_use_r;
  logic [wl1nn_pkg::DIM_CW-1:0]       dims_in_use_r;
  logic [wl1nn_pkg::PT_CW-1:0]        np_w;
  logic [wl1nn_pkg::DIM_CW-1:0]       nd_w;

  logic [wl1nn_pkg::WEIGHT_BITS-1:0]  weight_r [MD];
  logic [wl1nn_pkg::COORD_BITS-1:0]   query_r  [MD];

  logic [wl1nn_pkg::PT_CW-1:0]        cnt_r, cnt_nxt;
  logic                               cmd_pop;
  logic                               pt_we;
  logic                               search_cmd;
  logic                               search_start;
  logic                               issue;
  logic                               done;
  logic                               out_free;

  logic                               s1_v_r, s2_v_r, s3_v_r, s4_v_r;
  logic [wl1nn_pkg::PT_AW-1:0]        s1_idx_r, s2_idx_r, s3_idx_r, s4_idx_r;
  logic [wl1nn_pkg::COORD_BITS-1:0]   rd_data_r [MD];
  logic [wl1nn_pkg::PROD_W-1:0]       prod_r    [MD];
  logic [wl1nn_pkg::GRP_W-1:0]        grp_r     [wl1nn_pkg::NGRP];
  logic [wl1nn_pkg::SUM_W-1:0]        tot_r;
  logic [wl1nn_pkg::SUM_W-1:0]        tot_nxt;

  logic                               have_r;
  logic [wl1nn_pkg::PT_AW-1:0]        best_idx_r;
  logic [wl1nn_pkg::SUM_W-1:0]        best_dist_r;

  logic                               out_valid_r;
  logic [wl1nn_pkg::IDX_OUT_W-1:0]    out_idx_r;
  logic [wl1nn_pkg::DIST_W-1:0]       out_dist_r;
  logic                               out_found_r;

  // Saturate the configuration to the store size.
  assign np_w = (points_in_use_r > wl1nn_pkg::CFG_DATA_W'(wl1nn_pkg::MAX_POINTS))
              ? wl1nn_pkg::PT_CW'(wl1nn_pkg::MAX_POINTS)
              : wl1nn_pkg::PT_CW'(points_in_use_r);
  assign nd_w = (dims_in_use_r > wl1nn_pkg::DIM_CW'(MD))
              ? wl1nn_pkg::DIM_CW'(MD) : dims_in_use_r;

  assign out_free   = !out_valid_r || out_ready;
  assign search_cmd = (cmd.op == wl1nn_pkg::REQ_QUERY) && cmd.last;
  assign cmd_pop    = cmd_valid && cmd_ready;
  assign pt_we      = cmd_pop && (cmd.op == wl1nn_pkg::REQ_POINT) && cmd.slot_ok;
  assign search_start = cmd_pop && search_cmd;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      wl1nn_pkg::ST_IDLE: begin
        if (search_start) begin
          state_nxt = wl1nn_pkg::ST_SEARCH;
        end
      end
      wl1nn_pkg::ST_SEARCH: begin
        if (done) begin
          state_nxt = wl1nn_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = wl1nn_pkg::ST_IDLE;
      end
    endcase
  end

  // A search starts only with the result register free, so the finish
  // can always load it.
  always_comb begin
    cmd_ready = 1'b0;
    issue     = 1'b0;
    done      = 1'b0;
    case (state_r)
      wl1nn_pkg::ST_IDLE: begin
        cmd_ready = !search_cmd || out_free;
      end
      wl1nn_pkg::ST_SEARCH: begin
        issue = cnt_r < np_w;
        done  = (cnt_r == np_w) && !s1_v_r && !s2_v_r && !s3_v_r && !s4_v_r;
      end
      default: begin
        cmd_ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (search_start) begin
      cnt_nxt = '0;
    end else if (issue) begin
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= wl1nn_pkg::ST_IDLE;
      cnt_r           <= '0;
      points_in_use_r <= '0;
      dims_in_use_r   <= wl1nn_pkg::DIM_CW'(8);
      for (int i = 0; i < MD; i++) begin
        weight_r[i] <= wl1nn_pkg::WEIGHT_ONE;
        query_r[i]  <= '0;
      end
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_we) begin
        case (cfg_index)
          wl1nn_pkg::CFG_POINTS_IN_USE: points_in_use_r <= cfg_data;
          wl1nn_pkg::CFG_DIMS_IN_USE:   dims_in_use_r   <= cfg_data[wl1nn_pkg::DIM_CW-1:0];
          default: begin
          end
        endcase
      end
      if (cmd_pop && cmd.slot_ok) begin
        if (cmd.op == wl1nn_pkg::REQ_WEIGHT) begin
          weight_r[cmd.dim_slot[wl1nn_pkg::DIM_AW-1:0]] <= cmd.coord;
        end else if (cmd.op == wl1nn_pkg::REQ_QUERY) begin
          query_r[cmd.dim_slot[wl1nn_pkg::DIM_AW-1:0]] <= cmd.coord;
        end
      end
    end
  end

  // One memory lane per dimension; all lanes read the same point each cycle.
  for (genvar d = 0; d < MD; d++) begin : g_lane
    logic [wl1nn_pkg::COORD_BITS-1:0] mem [wl1nn_pkg::MAX_POINTS];
    logic signed [wl1nn_pkg::COORD_BITS:0] diff;
    logic [wl1nn_pkg::ABS_W-1:0]           absd;
    logic                                  lane_en;

    always_ff @(posedge clk) begin
      if (pt_we && (cmd.dim_slot == wl1nn_pkg::DSLOT_W'(d))) begin
        mem[cmd.point_slot[wl1nn_pkg::PT_AW-1:0]] <= cmd.coord;
      end
      rd_data_r[d] <= mem[cnt_r[wl1nn_pkg::PT_AW-1:0]];
    end

    assign diff = $signed({query_r[d][wl1nn_pkg::COORD_BITS-1], query_r[d]})
                - $signed({rd_data_r[d][wl1nn_pkg::COORD_BITS-1], rd_data_r[d]});
    assign absd = diff[wl1nn_pkg::COORD_BITS] ? wl1nn_pkg::ABS_W'(-diff)
                                              : wl1nn_pkg::ABS_W'(diff);
    assign lane_en = wl1nn_pkg::DIM_CW'(d) < nd_w;

    always_ff @(posedge clk) begin
      prod_r[d] <= lane_en ? wl1nn_pkg::PROD_W'(absd) * wl1nn_pkg::PROD_W'(weight_r[d])
                           : '0;
    end
  end

  for (genvar g = 0; g < wl1nn_pkg::NGRP; g++) begin : g_grp
    always_ff @(posedge clk) begin
      if (2 * g + 1 < MD) begin
        grp_r[g] <= wl1nn_pkg::GRP_W'(prod_r[2 * g]) + wl1nn_pkg::GRP_W'(prod_r[2 * g + 1]);
      end else begin
        grp_r[g] <= wl1nn_pkg::GRP_W'(prod_r[2 * g]);
      end
    end
  end

  always_comb begin
    tot_nxt = '0;
    for (int g = 0; g < wl1nn_pkg::NGRP; g++) begin
      tot_nxt = tot_nxt + wl1nn_pkg::SUM_W'(grp_r[g]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      have_r <= 1'b0;
    end else begin
      s1_v_r <= issue;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
      if (search_start) begin
        have_r <= 1'b0;
      end else if (s4_v_r) begin
        have_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_idx_r <= cnt_r[wl1nn_pkg::PT_AW-1:0];
    s2_idx_r <= s1_idx_r;
    s3_idx_r <= s2_idx_r;
    s4_idx_r <= s3_idx_r;
    tot_r    <= tot_nxt;
    // Strictly smaller only, so the lowest index keeps a tie.
    if (s4_v_r && (!have_r || tot_r < best_dist_r)) begin
      best_idx_r  <= s4_idx_r;
      best_dist_r <= tot_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_found_r <= have_r;
      out_idx_r   <= have_r ? wl1nn_pkg::IDX_OUT_W'(best_idx_r) : '0;
      out_dist_r  <= have_r ? wl1nn_pkg::DIST_W'(best_dist_r) : '0;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_nearest_index    = out_idx_r;
  assign out_nearest_distance = out_dist_r;
  assign out_found            = out_found_r;

  a_result_from_search : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == wl1nn_pkg::ST_SEARCH)
    else $error("result appeared without a search");

  a_issue_bound : assert property (@(posedge clk) disable iff (!rst_n)
    state_r == wl1nn_pkg::ST_SEARCH |-> cnt_r <= np_w)
    else $error("point counter ran past the points in use");

  a_found_index : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_found_r |-> wl1nn_pkg::PT_CW'(out_idx_r) < np_w)
    else $error("nearest index outside the points in use");

  a_empty_result : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_found_r |-> out_dist_r == '0 && out_idx_r == '0)
    else $error("empty search returned a nonzero result");

endmodule

// ----- design/weighted_l1_nearest_neighbor_top.sv -----
// Weighted Manhattan nearest-neighbor search. Point, weight and query items
// are accepted into a four-entry command queue and wait there while a
// search runs. A query item marked last runs a search that reads one
// stored point per cycle from eight parallel dimension memories and sums
// weight times absolute difference through the read, product, pair sum and
// total pipeline registers, at the rate set by the single read port of the
// point memories. The result waits in an output register while the queue
// keeps accepting items; a new search begins once that register is free.
// Point coordinates must be written before a search reads them.
module weighted_l1_nearest_neighbor_top (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic [1:0]                              in_req_type,
  input  logic [wl1nn_pkg::SLOT_W-1:0]            in_point_slot,
  input  logic [wl1nn_pkg::DSLOT_W-1:0]           in_dim_slot,
  input  logic signed [wl1nn_pkg::COORD_BITS-1:0] in_coord_value,
  input  logic                                    in_query_last,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic [wl1nn_pkg::IDX_OUT_W-1:0]         out_nearest_index,
  output logic [wl1nn_pkg::DIST_W-1:0]            out_nearest_distance,
  output logic                                    out_found,
  input  logic                                    cfg_we,
  input  logic [wl1nn_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [wl1nn_pkg::CFG_DATA_W-1:0]        cfg_data
);

  logic            cmd_valid;
  logic            cmd_ready;
  wl1nn_pkg::cmd_t cmd;

  wl1nn_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_point_slot  (in_point_slot),
    .in_dim_slot    (in_dim_slot),
    .in_coord_value (in_coord_value),
    .in_query_last  (in_query_last),
    .cmd_valid      (cmd_valid),
    .cmd_ready      (cmd_ready),
    .cmd            (cmd)
  );

  wl1nn_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd_valid            (cmd_valid),
    .cmd_ready            (cmd_ready),
    .cmd                  (cmd),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_nearest_index    (out_nearest_index),
    .out_nearest_distance (out_nearest_distance),
    .out_found            (out_found)
  );

endmodule
